@@ src/rpwd_pkg.sv @@
package rpwd_pkg;

   localparam int TS_W           = 24;
   localparam int MODE_W         = 2;
   localparam int CODE_W         = 24;
   localparam int UNIT_W         = 16;
   localparam int DUTY_W         = 8;
   localparam int PCT_W          = 7;
   localparam int TOL_W          = 6;
   localparam int CSR_IDX_W      = 2;
   localparam int NUM_W          = 31;
   localparam int DIV_W          = TS_W + DUTY_W;
   localparam int STEP_W         = 4;
   localparam int PCT_SCALE      = 100;
   localparam int FRAME_BITS_DEF = 24;

   localparam int REQ_TDATA_W = 24;
   localparam int REQ_TUSER_W = MODE_W;
   localparam int RSP_TDATA_W = 56;

   localparam logic [DUTY_W-1:0] DUTY_SAT = 8'd255;

   localparam logic [PCT_W-1:0] SYNC_DUTY_RST = 7'd8;
   localparam logic [PCT_W-1:0] ZERO_DUTY_RST = 7'd25;
   localparam logic [PCT_W-1:0] ONE_DUTY_RST  = 7'd75;
   localparam logic [TOL_W-1:0] TOL_RST       = 6'd10;

   typedef enum logic [MODE_W-1:0] {
      MODE_PERIOD  = 2'd0,
      MODE_PULSE   = 2'd1,
      MODE_ENABLE  = 2'd2,
      MODE_DISABLE = 2'd3
   } mode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SYNC_DUTY = 2'd0,
      CSR_ZERO_DUTY = 2'd1,
      CSR_ONE_DUTY  = 2'd2,
      CSR_TOLERANCE = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic              done;
      logic [DUTY_W-1:0] quot;
   } div_stat_type;

endpackage

@@ src/rpwd_div.sv @@
module rpwd_div
   import rpwd_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  logic [TS_W-1:0] width,
   input  logic [TS_W-1:0] period,
   output div_stat_type    stat
);

   typedef enum logic {
      D_IDLE,
      D_RUN
   } dstate_type;

   dstate_type        state_ff, state_in;
   logic [NUM_W-1:0]  rem_ff, rem_in;
   logic [DIV_W-1:0]  dsh_ff, dsh_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [DUTY_W-1:0] quot_ff, quot_in;
   logic              done_ff, done_in;
   logic [DIV_W:0]    diff;
   logic              ge;

   // one shared compare and subtract
   assign diff = {1'b0, DIV_W'(rem_ff)} - {1'b0, dsh_ff};
   assign ge   = ~diff[DIV_W];

   always_comb begin
      state_in = state_ff;
      rem_in   = rem_ff;
      dsh_in   = dsh_ff;
      step_in  = step_ff;
      quot_in  = quot_ff;
      done_in  = 1'b0;
      case (state_ff)
         D_IDLE: begin
            if (start) begin
               rem_in   = NUM_W'(width) * NUM_W'(PCT_SCALE);
               dsh_in   = {period, {DUTY_W{1'b0}}};
               step_in  = '0;
               quot_in  = '0;
               state_in = D_RUN;
            end
         end
         D_RUN: begin
            dsh_in = dsh_ff >> 1;
            if (step_ff == '0) begin
               // quotient of 256 or more saturates
               if (ge) begin
                  quot_in  = DUTY_SAT;
                  done_in  = 1'b1;
                  state_in = D_IDLE;
               end else begin
                  step_in = step_ff + 1'b1;
               end
            end else begin
               if (ge) begin
                  rem_in = diff[NUM_W-1:0];
               end
               quot_in = {quot_ff[DUTY_W-2:0], ge};
               if (step_ff == STEP_W'(DUTY_W)) begin
                  done_in  = 1'b1;
                  state_in = D_IDLE;
               end else begin
                  step_in = step_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = D_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= D_IDLE;
         done_ff  <= 1'b0;
         rem_ff   <= '0;
         dsh_ff   <= '0;
         step_ff  <= '0;
         quot_ff  <= '0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
         rem_ff   <= rem_in;
         dsh_ff   <= dsh_in;
         step_ff  <= step_in;
         quot_ff  <= quot_in;
      end
   end

   assign stat.done = done_ff;
   assign stat.quot = quot_ff;

endmodule

@@ src/rf_pulse_width_code_decoder.sv @@
// Pulse-width RF code receiver. Each req transfer carries one timestamped edge or
// one command (tuser: 0 period-start edge, 1 pulse-end edge, 2 enable and clear,
// 3 disable and clear) and yields exactly one rsp transfer. A period-start edge on
// an armed receiver with a nonzero period goes through a restoring divider
// for the duty percentage. Its first step checks for a quotient of 256 or more,
// which ends the division at once with 255. Otherwise eight further steps
// produce one quotient bit each. Such an item then passes through the S_FIN
// state, all other items go straight to S_FIN, and there the result is loaded
// into the rsp output register. One item is in work at a time. req_tready is low
// from acceptance until the result is loaded into the output register. That
// register may still hold an untaken result when the next item is accepted, and
// the load waits while it stays full. The csr port writes the duty thresholds and
// tolerance and should only be used while the block is idle.
module rf_pulse_width_code_decoder
   import rpwd_pkg::*;
#(
   parameter int FRAME_BITS = FRAME_BITS_DEF
)
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,  // timestamp[23:0]
   input  logic [REQ_TUSER_W-1:0] req_tuser,  // mode[1:0]
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // frame_done[0], confirmed[1], code[25:2], unit_time[41:26], duty[49:42],
   // armed[50], zero fill[55:51]
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   input  logic                   csr_we,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [PCT_W-1:0]       csr_wdata
);

   localparam int BL_W = $clog2(FRAME_BITS + 1);

   typedef enum logic [1:0] {
      S_IDLE,
      S_DIV,
      S_FIN
   } state_type;

   state_type             state_ff, state_in;
   mode_type              mode_ff, mode_in;
   logic [TS_W-1:0]       ts_ff, ts_in;
   logic [TS_W-1:0]       period_ff, period_in;
   logic [TS_W-1:0]       pst_ff, pst_in;
   logic [TS_W-1:0]       pw_ff, pw_in;
   logic                  in_frame_ff, in_frame_in;
   logic [BL_W-1:0]       bits_left_ff, bits_left_in;
   logic [FRAME_BITS-1:0] shift_ff, shift_in;
   logic [UNIT_W-1:0]     sync_width_ff, sync_width_in;
   logic [FRAME_BITS-1:0] stored_ff, stored_in;
   logic [UNIT_W-1:0]     unit_ff, unit_in;
   logic                  receiving_ff, receiving_in;
   logic [PCT_W-1:0]      sync_duty_ff, sync_duty_in;
   logic [PCT_W-1:0]      zero_duty_ff, zero_duty_in;
   logic [PCT_W-1:0]      one_duty_ff, one_duty_in;
   logic [TOL_W-1:0]      tol_ff, tol_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic                  accept;
   logic                  out_free;
   logic [TS_W-1:0]       period_now;
   logic                  div_start;
   div_stat_type          div_stat;
   logic                  period_ok;
   logic [DUTY_W-1:0]     duty_v;
   logic                  is_zero;
   logic                  is_one;
   logic [FRAME_BITS-1:0] shifted;
   logic [BL_W-1:0]       bl_next;
   logic                  done_v;
   logic                  conf_v;

   function automatic logic near_f(input logic [DUTY_W-1:0] d,
                                   input logic [PCT_W-1:0]  n,
                                   input logic [TOL_W-1:0]  t);
      logic [DUTY_W:0] dt;
      logic [DUTY_W:0] nt;
      dt = (DUTY_W+1)'(d) + (DUTY_W+1)'(t);
      nt = (DUTY_W+1)'(n) + (DUTY_W+1)'(t);
      return (dt >= (DUTY_W+1)'(n)) && ((DUTY_W+1)'(d) <= nt);
   endfunction

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid & req_tready;
   assign out_free   = ~rsp_valid_ff | rsp_tready;
   assign period_now = req_tdata[TS_W-1:0] - pst_ff;
   assign div_start  = accept && (mode_type'(req_tuser) == MODE_PERIOD) && receiving_ff
                       && (period_now != '0);

   rpwd_div u_div (
      .clock  (clock),
      .reset  (reset),
      .start  (div_start),
      .width  (pw_ff),
      .period (period_now),
      .stat   (div_stat)
   );

   always_comb begin
      state_in      = state_ff;
      mode_in       = mode_ff;
      ts_in         = ts_ff;
      period_in     = period_ff;
      pst_in        = pst_ff;
      pw_in         = pw_ff;
      in_frame_in   = in_frame_ff;
      bits_left_in  = bits_left_ff;
      shift_in      = shift_ff;
      sync_width_in = sync_width_ff;
      stored_in     = stored_ff;
      unit_in       = unit_ff;
      receiving_in  = receiving_ff;
      sync_duty_in  = sync_duty_ff;
      zero_duty_in  = zero_duty_ff;
      one_duty_in   = one_duty_ff;
      tol_in        = tol_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;

      period_ok = (period_ff != '0);
      if (mode_ff == MODE_PERIOD && receiving_ff) begin
         duty_v = period_ok ? div_stat.quot : DUTY_SAT;
      end else begin
         duty_v = '0;
      end
      is_zero = period_ok && near_f(duty_v, zero_duty_ff, tol_ff);
      is_one  = period_ok && !is_zero && near_f(duty_v, one_duty_ff, tol_ff);
      shifted = shift_ff >> 1;
      shifted[FRAME_BITS-1] = is_one;
      bl_next = (bits_left_ff != '0) ? bits_left_ff - 1'b1 : '0;
      done_v  = 1'b0;
      conf_v  = 1'b0;

      if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_SYNC_DUTY: sync_duty_in = csr_wdata;
            CSR_ZERO_DUTY: zero_duty_in = csr_wdata;
            CSR_ONE_DUTY:  one_duty_in  = csr_wdata;
            CSR_TOLERANCE: tol_in       = csr_wdata[TOL_W-1:0];
            default:       tol_in       = tol_ff;
         endcase
      end

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               mode_in   = mode_type'(req_tuser);
               ts_in     = req_tdata[TS_W-1:0];
               period_in = period_now;
               state_in  = div_start ? S_DIV : S_FIN;
            end
         end
         S_DIV: begin
            if (div_stat.done) begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            if (out_free) begin
               case (mode_ff)
                  MODE_ENABLE: begin
                     pst_in       = '0;
                     pw_in        = '0;
                     in_frame_in  = 1'b0;
                     stored_in    = '0;
                     receiving_in = 1'b1;
                  end
                  MODE_DISABLE: begin
                     pst_in       = '0;
                     pw_in        = '0;
                     in_frame_in  = 1'b0;
                     receiving_in = 1'b0;
                  end
                  MODE_PULSE: begin
                     if (receiving_ff) begin
                        pw_in = period_ff;
                     end
                  end
                  MODE_PERIOD: begin
                     if (receiving_ff) begin
                        pst_in = ts_ff;
                        if (!in_frame_ff) begin
                           if (period_ok && duty_v <= DUTY_W'(sync_duty_ff)) begin
                              sync_width_in = pw_ff[UNIT_W-1:0];
                              in_frame_in   = 1'b1;
                              bits_left_in  = BL_W'(FRAME_BITS);
                              shift_in      = '0;
                           end
                        end else if (is_zero || is_one) begin
                           shift_in     = shifted;
                           bits_left_in = bl_next;
                           if (bl_next == '0) begin
                              in_frame_in = 1'b0;
                              unit_in     = ~sync_width_ff;
                              done_v      = 1'b1;
                              if (stored_ff == shifted) begin
                                 conf_v       = 1'b1;
                                 pst_in       = '0;
                                 pw_in        = '0;
                                 receiving_in = 1'b0;
                              end else begin
                                 stored_in = shifted;
                              end
                           end
                        end else begin
                           in_frame_in = 1'b0;
                        end
                     end
                  end
                  default: begin
                     pst_in = pst_ff;
                  end
               endcase
               rsp_valid_in = 1'b1;
               rsp_data_in  = {5'b0, receiving_in, duty_v, unit_in,
                               CODE_W'(stored_in), conf_v, done_v};
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         mode_ff       <= MODE_PERIOD;
         ts_ff         <= '0;
         period_ff     <= '0;
         pst_ff        <= '0;
         pw_ff         <= '0;
         in_frame_ff   <= 1'b0;
         bits_left_ff  <= '0;
         shift_ff      <= '0;
         sync_width_ff <= '0;
         stored_ff     <= '0;
         unit_ff       <= '0;
         receiving_ff  <= 1'b1;
         sync_duty_ff  <= SYNC_DUTY_RST;
         zero_duty_ff  <= ZERO_DUTY_RST;
         one_duty_ff   <= ONE_DUTY_RST;
         tol_ff        <= TOL_RST;
         rsp_valid_ff  <= 1'b0;
         rsp_data_ff   <= '0;
      end else begin
         state_ff      <= state_in;
         mode_ff       <= mode_in;
         ts_ff         <= ts_in;
         period_ff     <= period_in;
         pst_ff        <= pst_in;
         pw_ff         <= pw_in;
         in_frame_ff   <= in_frame_in;
         bits_left_ff  <= bits_left_in;
         shift_ff      <= shift_in;
         sync_width_ff <= sync_width_in;
         stored_ff     <= stored_in;
         unit_ff       <= unit_in;
         receiving_ff  <= receiving_in;
         sync_duty_ff  <= sync_duty_in;
         zero_duty_ff  <= zero_duty_in;
         one_duty_ff   <= one_duty_in;
         tol_ff        <= tol_in;
         rsp_valid_ff  <= rsp_valid_in;
         rsp_data_ff   <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

@@ src/rpwd_checker.sv @@
module rpwd_checker
   import rpwd_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_tvalid,
   input logic                   req_tready,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_TDATA_W-1:0] rsp_tdata
);

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp payload changed while stalled");

   // one item in work at a time
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("req accepted while item in work");

   // confirmation implies a finished frame and a disarmed receiver
   a_confirm: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[1] |-> rsp_tdata[0] && !rsp_tdata[50])
      else $error("confirm without frame done or still armed");

   // a finished frame needs a valid duty
   a_frame_duty: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[0] |-> rsp_tdata[49:42] != DUTY_SAT)
      else $error("frame finished on invalid duty");

endmodule

bind rf_pulse_width_code_decoder rpwd_checker u_rpwd_checker (.*);
